// ----- rtl/irlm_pkg.sv -----
// shared types, lane constants and codes for the infrared range linearizer
package irlm_pkg;

  localparam int NumLanes  = 6;
  localparam int CountBits = 10;
  localparam int RangeBits = 17;
  localparam int CoefBits  = 14;
  localparam int CfgIdxBits = 8;

  localparam logic [RangeBits-1:0] RangeOne = 17'd65536;

  // register indexes
  localparam logic [CfgIdxBits-1:0] CfgLowCountThreshold = 8'd0;
  localparam logic [CfgIdxBits-1:0] CfgOverrideRange     = 8'd1;

  // lane slopes and offsets, units of 1e-4
  localparam logic signed [CoefBits-1:0] LaneM [NumLanes] = '{
    14'sd442, 14'sd373, 14'sd338, 14'sd328, 14'sd344, 14'sd337
  };
  localparam logic signed [CoefBits-1:0] LaneB [NumLanes] = '{
    -14'sd1647, -14'sd4953, 14'sd5689, 14'sd3003, 14'sd2421, 14'sd983
  };

  typedef struct packed {
    logic [CountBits-1:0] count_right_front;
    logic [CountBits-1:0] count_right_back;
    logic [CountBits-1:0] count_front_left;
    logic [CountBits-1:0] count_left_back;
    logic [CountBits-1:0] count_left_front;
    logic [CountBits-1:0] count_front_right;
  } in_word_t;

  typedef struct packed {
    logic [RangeBits-1:0] range_right_front;
    logic [RangeBits-1:0] range_right_back;
    logic [RangeBits-1:0] range_front_left;
    logic [RangeBits-1:0] range_left_back;
    logic [RangeBits-1:0] range_left_front;
    logic [RangeBits-1:0] range_front_right;
  } out_word_t;

  // per-lane setup from the top level
  typedef struct packed {
    logic                 start;
    logic [CountBits-1:0] threshold;
    logic [RangeBits-1:0] override_rng;
  } lane_ctl_t;

endpackage

// ----- rtl/irlm_lane.sv -----
// one lane: count to range by serial division, then median of three
module irlm_lane import irlm_pkg::*; #(
  parameter logic signed [CoefBits-1:0] M_COEF = '0,
  parameter logic signed [CoefBits-1:0] B_COEF = '0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lane_ctl_t            ctl_i,
  input  logic [CountBits-1:0] count_i,
  output logic                 done_o,
  output logic [RangeBits-1:0] range_o
);

  localparam int DBits   = CoefBits + CountBits + 2;
  localparam int NumBits = 38;
  localparam int DenBits = 28;
  localparam int QBits   = 18;
  localparam int RemBits = DenBits + 1;
  localparam int CntBits = $clog2(QBits);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StMul  = 3'd1;
  localparam logic [2:0] StPrep = 3'd2;
  localparam logic [2:0] StOvf  = 3'd3;
  localparam logic [2:0] StDiv  = 3'd4;
  localparam logic [2:0] StFin  = 3'd5;

  logic [2:0]               state_q, state_d;
  logic                     done_q, done_d;
  logic [CountBits-1:0]     count_q;
  logic                     low_q;
  logic [RangeBits-1:0]     ovr_q;
  logic signed [DBits-1:0]  d_q;
  logic [NumBits-1:0]       num_q;
  logic [DenBits-1:0]       den_q;
  logic [RemBits-1:0]       rem_q;
  logic [QBits-1:0]         quo_q;
  logic [CntBits-1:0]       cnt_q;
  logic [RangeBits-1:0]     r_q;
  logic [RangeBits-1:0]     h0_q, h1_q;
  logic [RangeBits-1:0]     out_q;

  logic [19:0]              d_u;
  logic [QBits-1:0]         num_lo;
  logic [RemBits-1:0]       rem_sh;
  logic                     rem_ge;

  function automatic logic [RangeBits-1:0] median3(logic [RangeBits-1:0] a,
                                                   logic [RangeBits-1:0] b,
                                                   logic [RangeBits-1:0] c);
    logic [RangeBits-1:0] lo, hi;
    lo = (a > b) ? b : a;
    hi = (a > b) ? a : b;
    if (hi > c) hi = c;
    return (lo > hi) ? lo : hi;
  endfunction

  assign d_u    = d_q[19:0];
  assign num_lo = num_q[QBits-1:0];
  assign rem_sh = {rem_q[RemBits-2:0], num_lo[cnt_q]};
  assign rem_ge = rem_sh >= {1'b0, den_q};

  // sequencer
  always_comb begin
    state_d = state_q;
    done_d  = done_q;
    unique case (state_q)
      StIdle: if (ctl_i.start) begin
        state_d = StMul;
        done_d  = 1'b0;
      end
      StMul:  state_d = StPrep;
      StPrep: begin
        if (low_q || d_q <= 0 || d_q >= DBits'(1000000)) state_d = StFin;
        else state_d = StOvf;
      end
      StOvf:  state_d = (DenBits'(num_q[NumBits-1:QBits]) >= den_q) ? StFin : StDiv;
      StDiv:  if (cnt_q == '0) state_d = StFin;
      StFin: begin
        state_d = StIdle;
        done_d  = 1'b1;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      done_q  <= 1'b0;
      h0_q    <= '0;
      h1_q    <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      if (state_q == StFin) begin
        h1_q <= h0_q;
        h0_q <= r_q;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      StIdle: begin
        count_q <= count_i;
        low_q   <= count_i < ctl_i.threshold;
        ovr_q   <= (ctl_i.override_rng > RangeOne) ? RangeOne : ctl_i.override_rng;
      end
      StMul: d_q <= DBits'(M_COEF) * DBits'($signed({1'b0, count_q})) + DBits'(B_COEF);
      StPrep: begin
        if (low_q) r_q <= ovr_q;
        else if (d_q == 0) r_q <= RangeOne;
        else r_q <= '0;
        num_q <= (NumBits'(20'd1000000 - d_u) << 17) + NumBits'(d_u) * NumBits'(100);
        den_q <= DenBits'(d_u) * DenBits'(200);
      end
      StOvf: begin
        r_q   <= RangeOne;
        rem_q <= RemBits'(num_q[NumBits-1:QBits]);
        cnt_q <= CntBits'(QBits - 1);
        quo_q <= '0;
      end
      StDiv: begin
        rem_q <= rem_ge ? rem_sh - {1'b0, den_q} : rem_sh;
        quo_q <= {quo_q[QBits-2:0], rem_ge};
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          if ({quo_q[QBits-2:0], rem_ge} > QBits'(RangeOne)) r_q <= RangeOne;
          else r_q <= RangeBits'({quo_q[QBits-2:0], rem_ge});
        end
      end
      StFin: out_q <= median3(r_q, h0_q, h1_q);
      default: ;
    endcase
  end

  assign done_o  = done_q;
  assign range_o = out_q;

endmodule

// ----- rtl/ir_range_linearize_median_unit.sv -----
// top level: config registers, six lanes and the merged output word
//
//  channel | signals                                   | role
//  in      | in_valid_i, in_stall_o, in_data_i          | frame of six counts
//  out     | out_valid_o, out_stall_i, out_data_o       | six median ranges
//  cfg     | cfg_valid_i, cfg_ready_o, cfg_index_i/data | register writes
//
// a frame runs multiply, prepare and finish in each lane on the override or
// out-of-range path; else an overflow check after prepare ends the frame when
// the range saturates, or else the lane runs its 18-step restoring divider.
// the next frame is taken once every lane has finished
// and its word is loaded into the output register. reset clears the range
// history to zero and loads the register defaults. a stalled output holds
// its word and the finished frame waits until the register frees.
module ir_range_linearize_median_unit import irlm_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_word_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_word_t             out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CfgIdxBits-1:0] cfg_index_i,
  input  logic [RangeBits-1:0]  cfg_data_i
);

  logic [CountBits-1:0] thr_q;
  logic [RangeBits-1:0] ovr_q;
  logic                 busy_q, out_valid_q;
  out_word_t            out_q;
  lane_ctl_t            ctl;
  logic                 accept;
  logic [NumLanes-1:0]  done;
  logic [CountBits-1:0] counts [NumLanes];
  logic [RangeBits-1:0] ranges [NumLanes];
  logic                 load;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = busy_q;
  assign accept      = in_valid_i && !busy_q;
  assign load        = busy_q && (&done) && (!out_valid_q || !out_stall_i);

  assign ctl.start        = accept;
  assign ctl.threshold    = thr_q;
  assign ctl.override_rng = ovr_q;

  // split the input word into lanes
  assign counts[0] = in_data_i.count_right_front;
  assign counts[1] = in_data_i.count_right_back;
  assign counts[2] = in_data_i.count_front_left;
  assign counts[3] = in_data_i.count_left_back;
  assign counts[4] = in_data_i.count_left_front;
  assign counts[5] = in_data_i.count_front_right;

  for (genvar g = 0; g < NumLanes; g++) begin : g_lane
    irlm_lane #(
      .M_COEF(LaneM[g]),
      .B_COEF(LaneB[g])
    ) u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl),
      .count_i(counts[g]),
      .done_o (done[g]),
      .range_o(ranges[g])
    );
  end

  // config registers and handshake control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q       <= 10'd50;
      ovr_q       <= RangeOne;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == CfgLowCountThreshold) thr_q <= cfg_data_i[CountBits-1:0];
        else if (cfg_index_i == CfgOverrideRange) ovr_q <= cfg_data_i;
      end
      if (accept) busy_q <= 1'b1;
      else if (load) busy_q <= 1'b0;
      if (load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // merge lanes into the output word
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q.range_right_front <= ranges[0];
      out_q.range_right_back  <= ranges[1];
      out_q.range_front_left  <= ranges[2];
      out_q.range_left_back   <= ranges[3];
      out_q.range_left_front  <= ranges[4];
      out_q.range_front_right <= ranges[5];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- verif/ir_range_linearize_median_unit_test.sv -----
// self-checking testbench for the infrared range linearizer with median filter
module ir_range_linearize_median_unit_test;
  import irlm_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int DrainCycles = 40;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  in_word_t              in_data_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  out_word_t             out_data_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CfgIdxBits-1:0] cfg_index_i;
  logic [RangeBits-1:0]  cfg_data_i;

  ir_range_linearize_median_unit dut (.*);

  // predictor state
  logic [CountBits-1:0] thresh_q;
  logic [RangeBits-1:0] ovr_q;
  logic [RangeBits-1:0] hist_new [NumLanes];
  logic [RangeBits-1:0] hist_old [NumLanes];
  out_word_t            range_queue [$];

  int send_idle_pct;
  int recv_idle_pct;
  bit hold_recv;
  int hold_cycles;
  int mismatches;
  int frames_sent;
  int words_seen;
  int cycle_count;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // timeout watchdog
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > CycleLimit) begin
        $display("timeout after %0d cycles", cycle_count);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // range of one lane from its count, Q1.16 rounded and saturated
  function automatic logic [RangeBits-1:0] lane_range(int lane, logic [CountBits-1:0] cnt);
    longint d;
    longint num;
    longint den;
    longint q;
    if (cnt < thresh_q) return (ovr_q > RangeOne) ? RangeOne : ovr_q;
    d = longint'(LaneM[lane]) * longint'(cnt) + longint'(LaneB[lane]);
    if (d == 0) return RangeOne;
    if (d < 0 || d >= 1000000) return '0;
    num = 65536 * (1000000 - d);
    den = 100 * d;
    q = (2 * num + den) / (2 * den);
    if (q > 65536) q = 65536;
    return q[RangeBits-1:0];
  endfunction

  function automatic logic [RangeBits-1:0] mid3(logic [RangeBits-1:0] a,
                                               logic [RangeBits-1:0] b,
                                               logic [RangeBits-1:0] c);
    logic [RangeBits-1:0] t;
    if (a > b) begin
      t = a; a = b; b = t;
    end
    if (b > c) b = c;
    return (a > b) ? a : b;
  endfunction

  // next filtered word from one frame, updates history
  function automatic out_word_t filter_frame(in_word_t w);
    logic [CountBits-1:0] c [NumLanes];
    logic [RangeBits-1:0] m [NumLanes];
    logic [RangeBits-1:0] r;
    out_word_t o;
    c = '{w.count_right_front, w.count_right_back, w.count_front_left,
          w.count_left_back, w.count_left_front, w.count_front_right};
    for (int i = 0; i < NumLanes; i++) begin
      r = lane_range(i, c[i]);
      m[i] = mid3(r, hist_new[i], hist_old[i]);
      hist_old[i] = hist_new[i];
      hist_new[i] = r;
    end
    o.range_right_front = m[0];
    o.range_right_back  = m[1];
    o.range_front_left  = m[2];
    o.range_left_back   = m[3];
    o.range_left_front  = m[4];
    o.range_front_right = m[5];
    return o;
  endfunction

  // send one frame word, valid drops only while the sender idles
  task automatic send_frame(in_word_t w);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    range_queue.push_back(filter_frame(w));
    frames_sent++;
  endtask

  // register write while idle
  task automatic write_reg(logic [CfgIdxBits-1:0] idx, logic [RangeBits-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == CfgLowCountThreshold) thresh_q = val[CountBits-1:0];
    else if (idx == CfgOverrideRange) ovr_q = val;
    @(posedge clk_i);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (range_queue.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic in_word_t rand_word();
    logic [63:0] raw;
    in_word_t w;
    raw = {$urandom, $urandom};
    w = raw[$bits(in_word_t)-1:0];
    // bias some lanes toward near-threshold and edge counts
    if ($urandom_range(3) == 0) w.count_front_left = CountBits'($urandom_range(60));
    if ($urandom_range(7) == 0) w.count_right_back = 10'h3ff;
    return w;
  endfunction

  function automatic in_word_t flat_word(logic [CountBits-1:0] v);
    return '{v, v, v, v, v, v};
  endfunction

  // receiver stall and result check
  always @(posedge clk_i) begin
    out_word_t exp_w;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        words_seen++;
        if (range_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected word %h", out_data_o);
        end else begin
          exp_w = range_queue.pop_front();
          if (exp_w.range_right_front !== out_data_o.range_right_front ||
              exp_w.range_right_back  !== out_data_o.range_right_back  ||
              exp_w.range_front_left  !== out_data_o.range_front_left  ||
              exp_w.range_left_back   !== out_data_o.range_left_back   ||
              exp_w.range_left_front  !== out_data_o.range_left_front  ||
              exp_w.range_front_right !== out_data_o.range_front_right) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %h actual %h", exp_w, out_data_o);
          end
        end
      end
      if (hold_recv) begin
        out_stall_i <= 1'b1;
        hold_cycles--;
        if (hold_cycles <= 0) hold_recv = 1'b0;
      end else begin
        out_stall_i <= (recv_idle_pct > 0) && ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // edge counts, zero and every lane's special denominators
  task automatic test_directed();
    send_frame(flat_word(10'd0));
    send_frame(flat_word(10'd49));
    send_frame(flat_word(10'd50));
    send_frame(flat_word(10'h3ff));
    send_frame(flat_word(10'h2aa));
    send_frame(flat_word(10'h155));
    send_frame(flat_word(10'd1));
    wait_idle();
    // threshold zero exposes negative and tiny denominators
    write_reg(CfgLowCountThreshold, 17'd0);
    for (int v = 0; v < 8; v++) send_frame(flat_word(v[CountBits-1:0] * 10'd3));
    send_frame(flat_word(10'd13));
    send_frame(flat_word(10'd14));
    send_frame(flat_word(10'h3ff));
    wait_idle();
    // override beyond one meter, then zero, with the threshold at the top
    write_reg(CfgLowCountThreshold, 17'd1023);
    write_reg(CfgOverrideRange, 17'h1ffff);
    send_frame(flat_word(10'd5));
    send_frame(flat_word(10'h3ff));
    wait_idle();
    write_reg(CfgOverrideRange, 17'd0);
    send_frame(flat_word(10'd1022));
    send_frame(flat_word(10'd0));
    wait_idle();
    // out-of-list register index is ignored
    write_reg(8'd7, 17'd12345);
    write_reg(CfgOverrideRange, 17'd30000);
    write_reg(CfgLowCountThreshold, 17'd50);
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) send_frame(rand_word());
  endtask

  // long receiver hold while frames keep coming
  task automatic test_backpressure();
    hold_cycles = 600;
    hold_recv   = 1'b1;
    test_random(20);
  endtask

  task automatic test_settings();
    for (int p = 0; p < 4; p++) begin
      wait_idle();
      write_reg(CfgLowCountThreshold, 17'($urandom_range(1023)));
      write_reg(CfgOverrideRange, 17'($urandom_range(65536 + 200)));
      test_random(150);
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_stall_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    hold_recv = 1'b0;
    hold_cycles = 0;
    mismatches = 0;
    frames_sent = 0;
    words_seen = 0;
    thresh_q = 10'd50;
    ovr_q = RangeOne;
    for (int i = 0; i < NumLanes; i++) begin
      hist_new[i] = '0;
      hist_old[i] = '0;
    end
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    send_idle_pct = 27;
    recv_idle_pct = 81;
    test_random(400);
    test_backpressure();
    send_idle_pct = 81;
    recv_idle_pct = 27;
    test_settings();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    wait_idle();
    write_reg(CfgLowCountThreshold, 17'd50);
    write_reg(CfgOverrideRange, RangeOne);
    test_random(780);
    wait_idle();

    $display("sent %0d frames, checked %0d words, %0d mismatches",
             frames_sent, words_seen, mismatches);
    $display("covered edge counts, override and threshold extremes, stalls");
    if (mismatches == 0 && range_queue.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/irlm_pkg.sv
rtl/irlm_lane.sv
rtl/ir_range_linearize_median_unit.sv
verif/ir_range_linearize_median_unit_test.sv
